// ----- design/ssmgp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ssmgp_pkg;

  localparam logic       MODE_WRITE   = 1'b0;
  localparam logic       MODE_TICK    = 1'b1;
  localparam logic [7:0] CODE_ZERO    = 8'hBB;
  localparam logic [7:0] POINT_CODE   = 8'h40;
  localparam logic [13:0] MAX_DECIMAL = 14'd9999;
  localparam logic [11:0] BRIGHT_RESET = 12'd1000;

  typedef struct packed {
    logic [15:0] pattern;
    logic [3:0]  enable_n;
  } ssmgp_tick_t;

  function automatic logic [7:0] digit_code(input logic [3:0] digit);
    logic [7:0] code;
    unique case (digit)
      4'd0:    code = 8'hBB;
      4'd1:    code = 8'h12;
      4'd2:    code = 8'h8F;
      4'd3:    code = 8'h1F;
      4'd4:    code = 8'h36;
      4'd5:    code = 8'h3D;
      4'd6:    code = 8'hBD;
      4'd7:    code = 8'h1A;
      4'd8:    code = 8'hBF;
      4'd9:    code = 8'h3E;
      default: code = CODE_ZERO;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ----- design/ssmgp_burst.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssmgp_burst #(
  parameter int NUM_DRIVERS = 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [11:0]          brightness_i,
  input  wire logic                 load_i,
  input  wire ssmgp_pkg::ssmgp_tick_t tick_i,
  output logic                      free_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [7:0]                serial_byte_o,
  output logic                      last_o,
  output logic                      latch_before_o,
  output logic [3:0]                digit_enable_n_o
);

  localparam int CH  = 16 * NUM_DRIVERS;
  localparam int CHW = $clog2(CH);
  localparam int PW  = CHW - 1;
  localparam logic [PW-1:0] LAST_PAIR = PW'(CH / 2 - 1);
  localparam logic [1:0] PH_HI  = 2'd0;
  localparam logic [1:0] PH_MID = 2'd1;
  localparam logic [1:0] PH_LO  = 2'd2;

  logic          busy_q;
  logic [PW-1:0] pair_q;
  logic [1:0]    phase_q;
  logic [15:0]   pat_q;
  logic [3:0]    en_q;

  logic          out_valid_q;
  logic [7:0]    byte_q;
  logic          last_q;
  logic          first_q;
  logic [3:0]    en_out_q;

  logic          out_take;
  logic          emit;
  logic          at_end;
  logic [CH-1:0] chan_vec;
  logic [CHW-1:0] hi_idx;
  logic [CHW-1:0] lo_idx;
  logic [11:0]   lvl_a;
  logic [11:0]   lvl_b;
  logic [7:0]    byte_d;

  assign out_take = !out_valid_q || !out_stall_i;
  assign emit     = busy_q && out_take;
  assign at_end   = (pair_q == LAST_PAIR) && (phase_q == PH_LO);
  assign free_o   = !busy_q || (emit && at_end);

  assign chan_vec = CH'(pat_q);
  assign hi_idx   = CHW'(CH - 1) - {pair_q, 1'b0};
  assign lo_idx   = hi_idx - CHW'(1);
  assign lvl_a    = chan_vec[hi_idx] ? brightness_i : 12'd0;
  assign lvl_b    = chan_vec[lo_idx] ? brightness_i : 12'd0;

  always_comb begin
    case (phase_q)
      PH_HI:   byte_d = lvl_a[11:4];
      PH_MID:  byte_d = {lvl_a[3:0], lvl_b[11:8]};
      PH_LO:   byte_d = lvl_b[7:0];
      default: byte_d = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pair_q      <= '0;
      phase_q     <= PH_HI;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        busy_q  <= 1'b1;
        pair_q  <= '0;
        phase_q <= PH_HI;
      end else if (emit && at_end) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        if (phase_q == PH_LO) begin
          phase_q <= PH_HI;
          pair_q  <= pair_q + PW'(1);
        end else begin
          phase_q <= phase_q + 2'd1;
        end
      end
      if (out_take) begin
        out_valid_q <= busy_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pat_q <= tick_i.pattern;
      en_q  <= tick_i.enable_n;
    end
    if (emit) begin
      byte_q   <= byte_d;
      last_q   <= at_end;
      first_q  <= (pair_q == '0) && (phase_q == PH_HI);
      en_out_q <= en_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign serial_byte_o    = byte_q;
  assign last_o           = last_q;
  assign latch_before_o   = first_q;
  assign digit_enable_n_o = en_out_q;

endmodule

`default_nettype wire

// ----- design/seven_segment_mux_grayscale_packer_core.sv -----
// Multiplexed seven-segment driver with a packed 12-bit grayscale stream.
// The input channel takes one request per item: mode 0 writes a decimal value
// (saturated at 9999) with an optional decimal point into one of two
// four-digit displays, and mode 1 is a multiplex tick. A write gives no output.
// A tick gives a burst of 24 * NUM_DRIVERS output bytes, one per cycle unless
// the receiver stalls, with latch_before on the first byte, last on the final
// byte and the anode select of the digit shown until now on every byte.
// Each request passes an input register and two decimal conversion stages;
// a tick then loads the burst generator, which feeds the output register.
// Writes are taken one per cycle unless a tick waits in the last stage.
// A tick holds the single burst generator for its whole burst, so the next
// tick is loaded in the cycle the last byte of the previous one moves into
// the output register.
// When the receiver stalls, the output register holds its byte, the generator
// waits, and the input stall rises while a tick waits in the last stage.
// The brightness register is written by cfg_we_i and resets to 1000.
// Reset clears the pipeline, sets every digit of both displays to zero and
// sets the digit counter to the first digit.
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_mux_grayscale_packer_core #(
  parameter int NUM_DRIVERS = 1
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [11:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic        display_select_i,
  input  wire logic [13:0] value_i,
  input  wire logic [2:0]  point_position_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       serial_byte_o,
  output logic             last_o,
  output logic             latch_before_o,
  output logic [3:0]       digit_enable_n_o
);

  logic [11:0] bright_q;

  logic        in_valid_q;
  logic        in_mode_q;
  logic        in_sel_q;
  logic [13:0] in_value_q;
  logic [2:0]  in_point_q;

  logic        a_valid_q;
  logic        a_mode_q;
  logic        a_sel_q;
  logic [13:0] a_val_q;
  logic [3:0]  a_q3_q;
  logic [2:0]  a_point_q;

  logic        b_valid_q;
  logic        b_mode_q;
  logic        b_sel_q;
  logic [9:0]  b_r3_q;
  logic [3:0]  b_q2_q;
  logic [3:0]  b_q3_q;
  logic [2:0]  b_point_q;

  logic [7:0]  disp_lo_q [4];
  logic [7:0]  disp_hi_q [4];
  logic [1:0]  digit_q;

  logic        adv;
  logic        b_go;
  logic        gen_free;
  logic        gen_load;
  logic        do_write;

  logic [13:0] val_sat;
  logic [27:0] prod_k;
  logic [13:0] r3_full;
  logic [15:0] prod_h;
  logic [9:0]  r2_full;
  logic [14:0] prod_t;
  logic [6:0]  r1_full;
  logic [3:0]  q1;
  logic [1:0]  pt_idx;
  logic [7:0]  codes [4];
  logic [1:0]  next_digit;
  ssmgp_pkg::ssmgp_tick_t tick;

  assign b_go       = b_valid_q && ((b_mode_q == ssmgp_pkg::MODE_WRITE) || gen_free);
  assign adv        = !b_valid_q || b_go;
  assign in_stall_o = !adv;
  assign gen_load   = b_valid_q && (b_mode_q == ssmgp_pkg::MODE_TICK) && gen_free;
  assign do_write   = b_valid_q && (b_mode_q == ssmgp_pkg::MODE_WRITE) && adv;

  assign val_sat = (in_value_q > ssmgp_pkg::MAX_DECIMAL) ? ssmgp_pkg::MAX_DECIMAL : in_value_q;
  assign prod_k  = 28'(val_sat) * 28'd8389;

  assign r3_full = a_val_q - (14'(a_q3_q) * 14'd1000);
  assign prod_h  = 16'(r3_full[9:0]) * 16'd41;

  assign r2_full = b_r3_q - (10'(b_q2_q) * 10'd100);
  assign prod_t  = 15'(r2_full[6:0]) * 15'd205;
  assign q1      = prod_t[14:11];
  assign r1_full = r2_full[6:0] - (7'(q1) * 7'd10);
  assign pt_idx  = 2'(b_point_q - 3'd1);

  always_comb begin
    codes[0] = ssmgp_pkg::digit_code(r1_full[3:0]);
    codes[1] = ssmgp_pkg::digit_code(q1);
    codes[2] = ssmgp_pkg::digit_code(b_q2_q);
    codes[3] = ssmgp_pkg::digit_code(b_q3_q);
    if ((b_point_q >= 3'd1) && (b_point_q <= 3'd4)) begin
      codes[pt_idx] = codes[pt_idx] | ssmgp_pkg::POINT_CODE;
    end
  end

  assign next_digit    = digit_q + 2'd1;
  assign tick.pattern  = {disp_hi_q[next_digit], disp_lo_q[next_digit]};
  assign tick.enable_n = ~(4'd1 << digit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q   <= ssmgp_pkg::BRIGHT_RESET;
      in_valid_q <= 1'b0;
      a_valid_q  <= 1'b0;
      b_valid_q  <= 1'b0;
      digit_q    <= 2'd0;
      for (int i = 0; i < 4; i++) begin
        disp_lo_q[i] <= ssmgp_pkg::CODE_ZERO;
        disp_hi_q[i] <= ssmgp_pkg::CODE_ZERO;
      end
    end else begin
      if (cfg_we_i) begin
        bright_q <= cfg_wdata_i;
      end
      if (adv) begin
        in_valid_q <= in_valid_i;
        a_valid_q  <= in_valid_q;
        b_valid_q  <= a_valid_q;
      end
      if (gen_load) begin
        digit_q <= next_digit;
      end
      if (do_write) begin
        for (int i = 0; i < 4; i++) begin
          if (b_sel_q) begin
            disp_hi_q[i] <= codes[i];
          end else begin
            disp_lo_q[i] <= codes[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_mode_q  <= mode_i;
      in_sel_q   <= display_select_i;
      in_value_q <= value_i;
      in_point_q <= point_position_i;
      a_mode_q   <= in_mode_q;
      a_sel_q    <= in_sel_q;
      a_val_q    <= val_sat;
      a_q3_q     <= prod_k[26:23];
      a_point_q  <= in_point_q;
      b_mode_q   <= a_mode_q;
      b_sel_q    <= a_sel_q;
      b_r3_q     <= r3_full[9:0];
      b_q2_q     <= prod_h[15:12];
      b_q3_q     <= a_q3_q;
      b_point_q  <= a_point_q;
    end
  end

  ssmgp_burst #(
    .NUM_DRIVERS(NUM_DRIVERS)
  ) u_burst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .brightness_i    (bright_q),
    .load_i          (gen_load),
    .tick_i          (tick),
    .free_o          (gen_free),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .serial_byte_o   (serial_byte_o),
    .last_o          (last_o),
    .latch_before_o  (latch_before_o),
    .digit_enable_n_o(digit_enable_n_o)
  );

endmodule

`default_nettype wire

// ----- design/ssmgp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssmgp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  serial_byte_o,
  input wire logic        last_o,
  input wire logic        latch_before_o,
  input wire logic [3:0]  digit_enable_n_o
);

  // A burst is never a single byte, so its first and last bytes differ.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(last_o && latch_before_o))
    else $error("first and last flags on the same byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(~digit_enable_n_o))
    else $error("anode select is not one-cold");

  // A byte that follows a taken byte inside one burst keeps the anode select.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=>
      (!out_valid_o || (!latch_before_o && $stable(digit_enable_n_o))))
    else $error("anode select changed inside a burst");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(serial_byte_o) && $stable(last_o)))
    else $error("stalled output request changed");

endmodule

bind seven_segment_mux_grayscale_packer_core ssmgp_checker u_checker (.*);

`default_nettype wire
